[hw/rtl/btm_pkg.sv]
package btm_pkg;

    typedef enum logic [3:0] {
        ST_DROPPED   = 4'd0,
        ST_CONTAINED = 4'd1,
        ST_INTERSECT = 4'd2,
        ST_APPENDED  = 4'd3,
        ST_FULL      = 4'd4,
        ST_CLEARED   = 4'd5,
        ST_READ      = 4'd6,
        ST_BAD_INDEX = 4'd7,
        ST_DISABLED  = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    localparam logic [1:0] REG_ENABLED   = 2'd0;
    localparam logic [1:0] REG_RATIO_NUM = 2'd1;
    localparam logic [1:0] REG_RATIO_DEN = 2'd2;

    typedef struct packed {
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] hx;
        logic signed [31:0] hy;
    } box_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [5:0]  slot;
        logic [6:0]  total;
        box_t        box;
    } result_t;

    function automatic logic inside_box(box_t a, box_t b);
        return (b.lx <= a.lx) && (a.hx <= b.hx) && (a.lx < a.hx) &&
               (b.ly <= a.ly) && (a.hy <= b.hy) && (a.ly < a.hy);
    endfunction

    function automatic logic covers_box(box_t a, box_t b);
        return (a.lx <= b.lx) && (b.hx <= a.hx) && (a.ly <= b.ly) && (b.hy <= a.hy);
    endfunction

    function automatic logic strict_overlap(box_t n, box_t o);
        return (n.hx > o.lx) && (n.lx < o.hx) && (n.hy > o.ly) && (n.ly < o.hy) &&
               !covers_box(n, o) && !covers_box(o, n);
    endfunction

    function automatic box_t isect_box(box_t n, box_t o);
        box_t x;
        x.lx = (n.lx > o.lx) ? n.lx : o.lx;
        x.ly = (n.ly > o.ly) ? n.ly : o.ly;
        x.hx = (n.hx < o.hx) ? n.hx : o.hx;
        x.hy = (n.hy < o.hy) ? n.hy : o.hy;
        return x;
    endfunction

endpackage

[hw/rtl/btm_area.sv]
module btm_area
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  btm_pkg::box_t  n_box,
    input  btm_pkg::box_t  o_box,
    input  btm_pkg::box_t  x_box,
    input  logic [7:0]     ratio_num,
    input  logic [7:0]     ratio_den,
    output logic           done,
    output logic           pass
);
    import btm_pkg::*;

    // one width product per cycle, then one scaling product per cycle
    logic [2:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [63:0] an_reg, ao_reg, ai_reg;
    logic [71:0] sn_reg, so_reg, si_reg;
    logic [32:0] wa, wb;
    logic [63:0] prod;
    logic [71:0] sprod;
    logic [39:0] sprod_hi, sprod_lo;
    logic [63:0] sop;
    logic [7:0]  sk;
    box_t        bsel;

    always_comb
    begin
        case (step_reg)
            3'd0:    bsel = n_box;
            3'd1:    bsel = o_box;
            default: bsel = x_box;
        endcase
        wa = 33'({bsel.hx[31], bsel.hx}) - 33'({bsel.lx[31], bsel.lx});
        wb = 33'({bsel.hy[31], bsel.hy}) - 33'({bsel.ly[31], bsel.ly});
        prod = (wa[32] || wa == '0 || wb[32] || wb == '0) ? 64'd0 :
               64'(wa[31:0]) * 64'(wb[31:0]);
        case (step_reg)
            3'd4:    begin sop = an_reg; sk = ratio_num; end
            3'd5:    begin sop = ao_reg; sk = ratio_num; end
            default: begin sop = ai_reg; sk = ratio_den; end
        endcase
        sprod_hi = 40'(sop[63:32]) * 40'(sk);
        sprod_lo = 40'(sop[31:0]) * 40'(sk);
        sprod = {sprod_hi, 32'd0} + 72'(sprod_lo);
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 3'd6)
                busy_next = 1'b0;
            else
                step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            case (step_reg)
                3'd0:    an_reg <= prod;
                3'd1:    ao_reg <= prod;
                3'd2:    ai_reg <= prod;
                3'd3:    si_reg <= sprod;
                3'd4:    sn_reg <= sprod;
                3'd5:    so_reg <= sprod;
                default: ;
            endcase
        end
    end

    assign done = busy_reg && step_reg == 3'd6;
    assign pass = (si_reg > sn_reg) || (si_reg > so_reg);
endmodule

[hw/rtl/box_table_merge_by_overlap.sv]
// box table with merge by overlap
// input channel: in_valid/in_ready carries mode, box and read_index; one beat
// per item. output channel: out_valid/out_ready carries one result beat.
// an insert runs a containment scan and an overlap scan over the table held
// in one synchronous memory: the first scan reads and compares each entry,
// the second reads each entry and, for a strict overlap, works out three areas,
// then three scaled areas, one product per cycle; a merge shifts entries down.
// the next beat is taken as soon as the block is back in idle, even if the
// receiver stalls; a stalled result blocks only the next result.
// reset empties the table (fill count zero), sets enabled to 0 and the ratio
// to 3/5; memory contents are left as they are.
// configuration goes through the APB port; write only while idle.
module box_table_merge_by_overlap #(
    parameter int MAX_BOXES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic signed [31:0] min_x,
    input  logic signed [31:0] min_y,
    input  logic signed [31:0] max_x,
    input  logic signed [31:0] max_y,
    input  logic [5:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [5:0]  slot,
    output logic [6:0]  entry_total,
    output logic signed [31:0] box_lo_x,
    output logic signed [31:0] box_lo_y,
    output logic signed [31:0] box_hi_x,
    output logic signed [31:0] box_hi_y
);
    import btm_pkg::*;

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN1  = 9'b000000010,
        S_SCAN2  = 9'b000000100,
        S_AREA   = 9'b000001000,
        S_SHIFTR = 9'b000010000,
        S_SHIFTW = 9'b000100000,
        S_PUT    = 9'b001000000,
        S_READ   = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    box_t mem [MAX_BOXES];

    state_t        state_reg, state_next;
    logic          enabled_reg, enabled_next;
    logic [7:0]    num_reg, num_next;
    logic [7:0]    den_reg, den_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          phase_reg, phase_next;
    box_t          nbox_reg, nbox_next;
    box_t          wbox_reg, wbox_next;
    box_t          rd_reg;
    result_t       pend_reg, pend_next;
    result_t       out_reg, out_next;
    logic          ov_reg, ov_next;
    logic          emit_go;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    box_t          wr_data;

    logic          area_start, area_done, area_pass;
    box_t          xbox;
    logic          cfg_wr;

    assign xbox = isect_box(nbox_reg, rd_reg);

    btm_area u_area (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (area_start),
        .n_box     (nbox_reg),
        .o_box     (rd_reg),
        .x_box     (xbox),
        .ratio_num (num_reg),
        .ratio_den (den_reg),
        .done      (area_done),
        .pass      (area_pass)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_ENABLED:   prdata = {31'd0, enabled_reg};
            REG_RATIO_NUM: prdata = {24'd0, num_reg};
            REG_RATIO_DEN: prdata = {24'd0, den_reg};
            default:       prdata = '0;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign emit_go  = (state_reg == S_EMIT) && (!ov_reg || out_ready);

    function automatic result_t mk(logic [3:0] st, logic [5:0] sl, logic [6:0] tot, box_t b);
        result_t r;
        r.status = st;
        r.slot   = sl;
        r.total  = tot;
        r.box    = b;
        return r;
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        enabled_next = enabled_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        phase_next   = phase_reg;
        nbox_next    = nbox_reg;
        wbox_next    = wbox_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        ov_next      = ov_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = idx_reg[AW-1:0];
        wr_data      = wbox_reg;
        area_start   = 1'b0;

        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ENABLED:   enabled_next = pwdata[0];
                REG_RATIO_NUM: num_next = pwdata[7:0];
                REG_RATIO_DEN: den_next = pwdata[7:0];
                default: ;
            endcase
        end

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    nbox_next.lx = min_x;
                    nbox_next.ly = min_y;
                    nbox_next.hx = max_x;
                    nbox_next.hy = max_y;
                    idx_next     = '0;
                    phase_next   = 1'b0;
                    case (mode_t'(mode))
                        MODE_CLEAR:
                        begin
                            fill_next = '0;
                            pend_next = mk(ST_CLEARED, 6'd0, 7'd0, '0);
                            state_next = S_EMIT;
                        end
                        MODE_READ:
                        begin
                            if (7'(read_index) < 7'(fill_reg))
                            begin
                                idx_next   = CW'(read_index);
                                state_next = S_READ;
                            end
                            else
                            begin
                                pend_next  = mk(ST_BAD_INDEX, read_index, 7'(fill_reg), '0);
                                state_next = S_EMIT;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (!enabled_reg)
                            begin
                                pend_next  = mk(ST_DISABLED, 6'd0, 7'(fill_reg), '0);
                                state_next = S_EMIT;
                            end
                            else
                                state_next = S_SCAN1;
                        end
                        default:
                        begin
                            pend_next  = mk(ST_BAD_INDEX, 6'd0, 7'(fill_reg), '0);
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (!phase_reg)
                begin
                    rd_en      = 1'b1;
                    phase_next = 1'b1;
                end
                else
                begin
                    pend_next  = mk(ST_READ, 6'(idx_reg), 7'(fill_reg), rd_reg);
                    state_next = S_EMIT;
                end
            end
            S_SCAN1:
            begin
                if (!phase_reg)
                begin
                    if (idx_reg >= fill_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_SCAN2;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    phase_next = 1'b0;
                    if (inside_box(rd_reg, nbox_reg))
                    begin
                        pend_next  = mk(ST_DROPPED, 6'(idx_reg), 7'(fill_reg), rd_reg);
                        state_next = S_EMIT;
                    end
                    else if (inside_box(nbox_reg, rd_reg))
                    begin
                        wbox_next  = nbox_reg;
                        pend_next  = mk(ST_CONTAINED, 6'(fill_reg - CW'(1)), 7'(fill_reg),
                                        nbox_reg);
                        state_next = S_SHIFTR;
                    end
                    else
                        idx_next = idx_reg + CW'(1);
                end
            end
            S_SCAN2:
            begin
                if (!phase_reg)
                begin
                    if (idx_reg >= fill_reg)
                    begin
                        if (fill_reg >= CW'(MAX_BOXES))
                        begin
                            pend_next  = mk(ST_FULL, 6'd0, 7'(fill_reg), '0);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            wbox_next  = nbox_reg;
                            pend_next  = mk(ST_APPENDED, 6'(fill_reg), 7'(fill_reg + CW'(1)),
                                            nbox_reg);
                            idx_next   = fill_reg;
                            fill_next  = fill_reg + CW'(1);
                            state_next = S_PUT;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    phase_next = 1'b0;
                    if (strict_overlap(nbox_reg, rd_reg) && den_reg != 8'd0)
                    begin
                        area_start = 1'b1;
                        state_next = S_AREA;
                    end
                    else
                        idx_next = idx_reg + CW'(1);
                end
            end
            S_AREA:
            begin
                if (area_done)
                begin
                    if (area_pass)
                    begin
                        wbox_next  = xbox;
                        pend_next  = mk(ST_INTERSECT, 6'(fill_reg - CW'(1)), 7'(fill_reg),
                                        xbox);
                        state_next = S_SHIFTR;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_SCAN2;
                    end
                end
            end
            S_SHIFTR:
            begin
                if (idx_reg + CW'(1) >= fill_reg)
                begin
                    idx_next   = fill_reg - CW'(1);
                    state_next = S_PUT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(idx_reg + CW'(1));
                    state_next = S_SHIFTW;
                end
            end
            S_SHIFTW:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_reg;
                idx_next   = idx_reg + CW'(1);
                state_next = S_SHIFTR;
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    out_next   = pend_reg;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            enabled_reg <= 1'b0;
            num_reg     <= 8'd3;
            den_reg     <= 8'd5;
            fill_reg    <= '0;
            idx_reg     <= '0;
            phase_reg   <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            enabled_reg <= enabled_next;
            num_reg     <= num_next;
            den_reg     <= den_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            phase_reg   <= phase_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nbox_reg <= nbox_next;
        wbox_reg <= wbox_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid   = ov_reg;
    assign status      = out_reg.status;
    assign slot        = out_reg.slot;
    assign entry_total = out_reg.total;
    assign box_lo_x    = out_reg.box.lx;
    assign box_lo_y    = out_reg.box.ly;
    assign box_hi_x    = out_reg.box.hx;
    assign box_hi_y    = out_reg.box.hy;
endmodule

[hw/rtl/btm_checker.sv]
module btm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] status,
    input logic [6:0] entry_total
);
    import btm_pkg::*;

    // a held result beat does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_total))
        else $error("output beat changed while stalled");

    // an offered input beat stays until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input beat withdrawn before accept");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= 4'(ST_DISABLED))
        else $error("status code out of range");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == 4'(ST_CLEARED) |-> entry_total == 7'd0)
        else $error("clear left entries");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_total <= 7'd64)
        else $error("entry total out of range");
endmodule

bind box_table_merge_by_overlap btm_checker u_btm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_total (entry_total)
);

[bench/box_table_merge_by_overlap_tb.sv]
`timescale 1ns / 100ps

module box_table_merge_by_overlap_tb;
    import btm_pkg::*;

    localparam int DEPTH = 32;
    localparam int UNIT = 65536;
    localparam int QUIET_CYCLES = 13 * DEPTH + 40;
    localparam int HOLD_CYCLES = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = MODE_INSERT;
    logic signed [31:0] min_x = '0;
    logic signed [31:0] min_y = '0;
    logic signed [31:0] max_x = '0;
    logic signed [31:0] max_y = '0;
    logic [5:0] read_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [3:0] status;
    logic [5:0] slot;
    logic [6:0] entry_total;
    logic signed [31:0] box_lo_x;
    logic signed [31:0] box_lo_y;
    logic signed [31:0] box_hi_x;
    logic signed [31:0] box_hi_y;

    box_table_merge_by_overlap #(.MAX_BOXES(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
        .min_x(min_x), .min_y(min_y), .max_x(max_x), .max_y(max_y),
        .read_index(read_index),
        .out_valid(out_valid), .out_ready(out_ready), .status(status), .slot(slot),
        .entry_total(entry_total), .box_lo_x(box_lo_x), .box_lo_y(box_lo_y),
        .box_hi_x(box_hi_x), .box_hi_y(box_hi_y)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the block
    box_t held [DEPTH];
    int held_count = 0;
    logic cfg_enabled = 1'b0;
    logic [7:0] cfg_num = 8'd3;
    logic [7:0] cfg_den = 8'd5;

    result_t pending_results [$];
    int errors = 0;
    int beats_in = 0;
    int status_seen [9];
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_request = 1'b0;

    function automatic box_t mk_box(longint lx, longint ly, longint hx, longint hy);
        box_t b;
        b.lx = lx[31:0];
        b.ly = ly[31:0];
        b.hx = hx[31:0];
        b.hy = hy[31:0];
        return b;
    endfunction

    function automatic bit box_within(box_t a, box_t b);
        return b.lx <= a.lx && a.hx <= b.hx && a.lx < a.hx &&
               b.ly <= a.ly && a.hy <= b.hy && a.ly < a.hy;
    endfunction

    function automatic bit box_covers(box_t a, box_t b);
        return a.lx <= b.lx && b.hx <= a.hx && a.ly <= b.ly && b.hy <= a.hy;
    endfunction

    function automatic bit boxes_overlap(box_t n, box_t o);
        if (!(n.hx > o.lx && n.lx < o.hx && n.hy > o.ly && n.ly < o.hy))
            return 1'b0;
        return !box_covers(n, o) && !box_covers(o, n);
    endfunction

    function automatic logic [63:0] box_area(box_t b);
        longint w;
        longint h;
        logic [63:0] uw;
        logic [63:0] uh;
        w = longint'(b.hx) - longint'(b.lx);
        h = longint'(b.hy) - longint'(b.ly);
        if (w <= 0 || h <= 0)
            return 64'd0;
        uw = w;
        uh = h;
        return uw * uh;
    endfunction

    function automatic bit beats_ratio(logic [63:0] part, logic [63:0] whole);
        logic [71:0] lhs;
        logic [71:0] rhs;
        lhs = 72'(part);
        rhs = 72'(whole);
        lhs = lhs * 72'(cfg_den);
        rhs = rhs * 72'(cfg_num);
        return lhs > rhs;
    endfunction

    function automatic int remove_and_append(int i, box_t b);
        for (int k = i; k + 1 < held_count; k++)
            held[k] = held[k + 1];
        held[held_count - 1] = b;
        return held_count - 1;
    endfunction

    function automatic result_t predict_result(logic [1:0] md, box_t nb, logic [5:0] idx);
        result_t r;
        box_t o;
        box_t x;
        logic [63:0] ia;
        bit done;
        r = '0;
        done = 1'b0;
        case (md)
            MODE_CLEAR:
            begin
                held_count = 0;
                r.status = ST_CLEARED;
            end
            MODE_READ:
            begin
                r.slot = idx;
                if (int'(idx) < held_count)
                begin
                    r.status = ST_READ;
                    r.box = held[idx];
                end
                else
                    r.status = ST_BAD_INDEX;
            end
            MODE_NONE:
                r.status = ST_BAD_INDEX;
            default:
            begin
                if (!cfg_enabled)
                    r.status = ST_DISABLED;
                else
                begin
                    for (int i = 0; i < held_count && !done; i++)
                    begin
                        o = held[i];
                        if (box_within(o, nb))
                        begin
                            r.status = ST_DROPPED;
                            r.slot = 6'(i);
                            r.box = o;
                            done = 1'b1;
                        end
                        else if (box_within(nb, o))
                        begin
                            r.status = ST_CONTAINED;
                            r.slot = 6'(remove_and_append(i, nb));
                            r.box = nb;
                            done = 1'b1;
                        end
                    end
                    for (int i = 0; i < held_count && !done; i++)
                    begin
                        o = held[i];
                        if (boxes_overlap(nb, o))
                        begin
                            x.lx = nb.lx > o.lx ? nb.lx : o.lx;
                            x.ly = nb.ly > o.ly ? nb.ly : o.ly;
                            x.hx = nb.hx < o.hx ? nb.hx : o.hx;
                            x.hy = nb.hy < o.hy ? nb.hy : o.hy;
                            ia = box_area(x);
                            if (beats_ratio(ia, box_area(nb)) || beats_ratio(ia, box_area(o)))
                            begin
                                r.status = ST_INTERSECT;
                                r.slot = 6'(remove_and_append(i, x));
                                r.box = x;
                                done = 1'b1;
                            end
                        end
                    end
                    if (!done)
                    begin
                        if (held_count >= DEPTH)
                            r.status = ST_FULL;
                        else
                        begin
                            held[held_count] = nb;
                            r.status = ST_APPENDED;
                            r.slot = 6'(held_count);
                            r.box = nb;
                            held_count++;
                        end
                    end
                end
            end
        endcase
        r.total = 7'(held_count);
        return r;
    endfunction

    function automatic void queue_expect(result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic send_item(logic [1:0] md, box_t b, logic [5:0] idx);
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;
        min_x <= b.lx;
        min_y <= b.ly;
        max_x <= b.hx;
        max_y <= b.hy;
        read_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        queue_expect(predict_result(md, b, idx));
        beats_in++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ENABLED: cfg_enabled = value[0];
            REG_RATIO_NUM: cfg_num = value[7:0];
            default: cfg_den = value[7:0];
        endcase
    endtask

    task automatic reg_read_check(logic [1:0] idx);
        logic [31:0] want;
        case (idx)
            REG_ENABLED: want = {31'd0, cfg_enabled};
            REG_RATIO_NUM: want = {24'd0, cfg_num};
            default: want = {24'd0, cfg_den};
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $display("%0t register %0d expected %h actual %h", $time, idx, want, prdata);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_ratio(logic [7:0] num, logic [7:0] den);
        reg_write(REG_RATIO_NUM, {24'd0, num});
        reg_write(REG_RATIO_DEN, {24'd0, den});
        reg_read_check(REG_RATIO_NUM);
        reg_read_check(REG_RATIO_DEN);
    endtask

    function automatic box_t random_box();
        longint lx;
        longint ly;
        if ($urandom_range(0, 6) == 0)
            return mk_box($urandom, $urandom, $urandom, $urandom);
        lx = (longint'($urandom_range(0, 40)) - 20) * UNIT / 4 + $urandom_range(0, 3) * 1024;
        ly = (longint'($urandom_range(0, 40)) - 20) * UNIT / 4 + $urandom_range(0, 3) * 1024;
        return mk_box(lx, ly, lx + longint'($urandom_range(1, 24)) * UNIT / 4,
                      ly + longint'($urandom_range(1, 24)) * UNIT / 4);
    endfunction

    task automatic send_random();
        int pick;
        logic [5:0] idx;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 7)
            idx = (held_count + 1 > 63) ? 6'd63 : 6'($urandom_range(0, held_count + 1));
        else
            idx = 6'($urandom_range(0, 63));
        if (pick < 80)
            send_item(MODE_INSERT, random_box(), idx);
        else if (pick < 94)
            send_item(MODE_READ, random_box(), idx);
        else if (pick < 97)
            send_item(MODE_NONE, random_box(), idx);
        else
            send_item(MODE_CLEAR, random_box(), idx);
    endtask

    task automatic run_random(int count);
        repeat (count) send_random();
        wait_idle();
    endtask

    // checking
    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result beat, status %0d", $time, status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.status < 9)
                    status_seen[want.status]++;
                check_field("status", want.status, status);
                check_field("slot", want.slot, slot);
                check_field("entry_total", want.total, entry_total);
                check_field("box_lo_x", want.box.lx, box_lo_x);
                check_field("box_lo_y", want.box.ly, box_lo_y);
                check_field("box_hi_x", want.box.hx, box_hi_x);
                check_field("box_hi_y", want.box.hy, box_hi_y);
            end
        end
    end

    // receiver
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (receiver_idles && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic test_registers_after_reset();
        reg_read_check(REG_ENABLED);
        reg_read_check(REG_RATIO_NUM);
        reg_read_check(REG_RATIO_DEN);
    endtask

    task automatic test_disabled_block();
        send_item(MODE_INSERT, mk_box(0, 0, UNIT, UNIT), 6'd0);
        send_item(MODE_READ, mk_box(0, 0, 0, 0), 6'd0);
        send_item(MODE_NONE, mk_box(0, 0, 0, 0), 6'd0);
        send_item(MODE_CLEAR, mk_box(0, 0, 0, 0), 6'd0);
        wait_idle();
        reg_write(REG_ENABLED, 32'd1);
        reg_read_check(REG_ENABLED);
    endtask

    task automatic test_merge_rules();
        send_item(MODE_INSERT, mk_box(0, 0, 4 * UNIT, 4 * UNIT), 6'd0);
        send_item(MODE_INSERT, mk_box(UNIT, UNIT, 2 * UNIT, 2 * UNIT), 6'd0);
        send_item(MODE_INSERT, mk_box(0, 0, 6 * UNIT, 6 * UNIT), 6'd0);
        send_item(MODE_INSERT, mk_box(UNIT + UNIT / 10, UNIT, 2 * UNIT + UNIT / 10, 2 * UNIT),
                  6'd0);
        send_item(MODE_INSERT, mk_box(10 * UNIT, 0, 12 * UNIT, 2 * UNIT), 6'd0);
        send_item(MODE_INSERT, mk_box(12 * UNIT, 0, 14 * UNIT, 2 * UNIT), 6'd0);
        send_item(MODE_INSERT, mk_box(11 * UNIT, UNIT, 13 * UNIT, 3 * UNIT), 6'd0);
        send_item(MODE_INSERT, mk_box(5 * UNIT, 5 * UNIT, -5 * UNIT, -5 * UNIT), 6'd0);
        send_item(MODE_INSERT, mk_box(20 * UNIT, 20 * UNIT, 20 * UNIT, 21 * UNIT), 6'd0);
        send_item(MODE_READ, mk_box(0, 0, 0, 0), 6'd0);
        send_item(MODE_READ, mk_box(0, 0, 0, 0), 6'd1);
        send_item(MODE_READ, mk_box(0, 0, 0, 0), 6'd63);
        send_item(MODE_INSERT, mk_box(-2147483648, -2147483648, 2147483647, 2147483647), 6'd0);
        send_item(MODE_CLEAR, mk_box(0, 0, 0, 0), 6'd0);
        send_item(MODE_INSERT, mk_box(-2147483648, -2147483648, 2147483647, 2147483647), 6'd0);
        send_item(MODE_INSERT, mk_box(-2147483648, 0, 2147483647, 1), 6'd0);
        send_item(MODE_READ, mk_box(-1, -1, -1, -1), 6'd0);
        send_item(MODE_CLEAR, mk_box(0, 0, 0, 0), 6'd0);
        wait_idle();
    endtask

    task automatic test_full_table();
        for (int i = 0; i <= DEPTH; i++)
            send_item(MODE_INSERT, mk_box(i * 2 * UNIT, 0, i * 2 * UNIT + UNIT, UNIT), 6'd0);
        send_item(MODE_READ, mk_box(0, 0, 0, 0), 6'(DEPTH - 1));
        send_item(MODE_READ, mk_box(0, 0, 0, 0), 6'(DEPTH));
        wait_idle();
    endtask

    task automatic test_output_stall();
        hold_request = 1'b1;
        repeat (40) send_random();
        wait_idle();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_registers_after_reset();
        test_disabled_block();
        test_merge_rules();
        test_full_table();
        test_output_stall();
        set_ratio(8'd3, 8'd5);
        run_random(200);
        set_ratio(8'd1, 8'd255);
        run_random(110);
        set_ratio(8'd255, 8'd1);
        run_random(80);
        reg_write(REG_ENABLED, 32'd0);
        run_random(20);
        reg_write(REG_ENABLED, 32'd1);
        set_ratio(8'd255, 8'd255);
        run_random(100);
        set_ratio(8'd3, 8'd5);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        run_random(150);
        $display("run covered %0d beats: dropped %0d, contained %0d, intersected %0d,",
                 beats_in, status_seen[0], status_seen[1], status_seen[2]);
        $display("appended %0d, full %0d, cleared %0d, read %0d, bad index %0d, disabled %0d",
                 status_seen[3], status_seen[4], status_seen[5], status_seen[6],
                 status_seen[7], status_seen[8]);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
